@@ hdl/lcr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants for the line command recognizer: command codes,
// keyword tables, queue entry layout and reset values.
// ----------------------------------------------------------------------------
package lcr_pkg;

   // Command codes as seen on the result channel
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_OFF     = 3'd3,
      CMD_SCALE_C = 3'd4,
      CMD_SCALE_F = 3'd5,
      CMD_PERIOD  = 3'd6
   } cmd_code_type;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_START_PERIOD = 1'b0,
      CSR_START_SCALE  = 1'b1
   } csr_index_type;

   // Number parse phase after the PERIOD= prefix
   typedef enum logic [1:0] {
      NUM_SKIP   = 2'd0,
      NUM_DIGITS = 2'd1,
      NUM_DONE   = 2'd2
   } num_phase_type;

   // Keyword slots
   localparam int KW_COUNT  = 6;
   localparam int KW_START  = 0;
   localparam int KW_STOP   = 1;
   localparam int KW_OFF    = 2;
   localparam int KW_SCALEC = 3;
   localparam int KW_SCALEF = 4;
   localparam int KW_PERIOD = 5;

   localparam int POS_W = 3;                 // line position, saturates at 7
   localparam logic [POS_W-1:0] PREFIX_LEN = 3'd7;
   localparam logic [POS_W-1:0] POS_MAX    = 3'd7;

   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
      '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"S", "C", "A", "L", "E", "=", "C", 8'h00},
      '{"S", "C", "A", "L", "E", "=", "F", 8'h00},
      '{"P", "E", "R", "I", "O", "D", "=", 8'h00}
   };
   localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd4, 3'd3, 3'd7, 3'd7, 3'd7};
   localparam cmd_code_type KW_CODE [KW_COUNT] = '{
      CMD_START, CMD_STOP, CMD_OFF, CMD_SCALE_C, CMD_SCALE_F, CMD_PERIOD
   };

   // Characters
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FORMFD  = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Number limits
   localparam int MAG_W = 16;
   localparam logic [MAG_W-1:0] MAG_LIMIT = 16'd32768;
   localparam logic [MAG_W-1:0] POS_LIMIT = 16'd32767;

   // Reset values of the configuration registers
   localparam logic signed [15:0] START_PERIOD_RESET = 16'sd1;
   localparam logic               START_SCALE_RESET  = 1'b1;

   localparam int CSR_DATA_W    = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // One classified line waiting for the back end
   typedef struct packed {
      cmd_code_type       code;
      logic signed [15:0] value;
   } cmd_entry_type;

endpackage : lcr_pkg
`default_nettype wire

@@ hdl/lcr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_front
// Byte front end: keyword-alive matching, streaming PERIOD number parse and
// line classification. Pushes one command entry per newline until OFF halts it.
// ----------------------------------------------------------------------------
module lcr_front
   import lcr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          byte_accept,
   input  wire logic [7:0]    text_byte,
   output      logic          push_valid,
   output      cmd_entry_type push_data
);

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [KW_COUNT-1:0] alive_ff, alive_in;
   num_phase_type       phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic [MAG_W-1:0]    acc_ff, acc_in;
   logic                halted_ff, halted_in;

   logic                is_newline, is_blank, is_digit, is_sign, num_active;
   logic [19:0]         acc_sum;
   cmd_code_type        line_code;
   logic signed [15:0]  line_value;

   assign is_newline = (text_byte == CHAR_NEWLINE);
   assign is_blank   = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB) ||
                       (text_byte == CHAR_VTAB) || (text_byte == CHAR_FORMFD) ||
                       (text_byte == CHAR_CR);
   assign is_digit   = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
   assign is_sign    = (text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS);
   assign num_active = (pos_ff == PREFIX_LEN) && alive_ff[KW_PERIOD];
   assign acc_sum    = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                       {16'd0, 4'(text_byte - CHAR_ZERO)};

   // Classify at newline: lowest keyword slot wins
   always_comb begin
      line_code = CMD_NONE;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (alive_ff[k]) begin
            if (k == KW_PERIOD) begin
               if (pos_ff >= PREFIX_LEN) line_code = KW_CODE[k];
            end else if (pos_ff == KW_LEN[k]) begin
               line_code = KW_CODE[k];
            end
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         line_value = signed'((~acc_ff) + 16'd1);
      end else if (acc_ff > POS_LIMIT) begin
         line_value = signed'(POS_LIMIT);
      end else begin
         line_value = signed'(acc_ff);
      end
   end

   // Next line state
   always_comb begin
      pos_in    = pos_ff;
      alive_in  = alive_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      halted_in = halted_ff;
      if (byte_accept && !halted_ff) begin
         if (is_newline) begin
            pos_in   = '0;
            alive_in = '1;
            phase_in = NUM_SKIP;
            neg_in   = 1'b0;
            acc_in   = '0;
            if (line_code == CMD_OFF) halted_in = 1'b1;
         end else begin
            for (int k = 0; k < KW_COUNT; k++) begin
               if (pos_ff < KW_LEN[k]) begin
                  if (KW_TEXT[k][pos_ff] != text_byte) alive_in[k] = 1'b0;
               end else if (k != KW_PERIOD) begin
                  alive_in[k] = 1'b0;
               end
            end
            if (pos_ff != POS_MAX) pos_in = pos_ff + 3'd1;
            if (num_active) begin
               unique case (phase_ff)
                  NUM_SKIP: begin
                     if (!is_blank) begin
                        if (is_sign) begin
                           phase_in = NUM_DIGITS;
                           neg_in   = (text_byte == CHAR_MINUS);
                        end else if (is_digit) begin
                           phase_in = NUM_DIGITS;
                           acc_in   = (acc_sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT
                                                                    : acc_sum[MAG_W-1:0];
                        end else begin
                           phase_in = NUM_DONE;
                        end
                     end
                  end
                  NUM_DIGITS: begin
                     if (is_digit) begin
                        acc_in = (acc_sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT
                                                               : acc_sum[MAG_W-1:0];
                     end else begin
                        phase_in = NUM_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   assign push_valid      = byte_accept && !halted_ff && is_newline;
   assign push_data.code  = line_code;
   assign push_data.value = line_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         alive_ff  <= '1;
         phase_ff  <= NUM_SKIP;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         alive_ff  <= alive_in;
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         acc_ff    <= acc_in;
         halted_ff <= halted_in;
      end
   end

endmodule : lcr_front
`default_nettype wire

@@ hdl/lcr_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_queue
// Short FIFO of classified command entries between front and back end.
// ----------------------------------------------------------------------------
module lcr_queue
   import lcr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire cmd_entry_type push_data,
   output      logic          full,
   output      logic          pop_valid,
   input  wire logic          pop_ready,
   output      cmd_entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_entry_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule : lcr_queue
`default_nettype wire

@@ hdl/lcr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcr_back
// Back end: applies commands to the running/scale/period/halted state and
// holds the result transaction in an output register.
// ----------------------------------------------------------------------------
module lcr_back
   import lcr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output      logic                  cmd_ready,
   input  wire cmd_entry_type         cmd_data,
   input  wire logic                  csr_write_enable,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [2:0]            rsp_command_code,
   output      logic signed [15:0]    rsp_period_value,
   output      logic                  rsp_running,
   output      logic                  rsp_scale_fahrenheit,
   output      logic                  rsp_shut_down
);

   logic               running_ff, running_in;
   logic               scale_ff, scale_in;
   logic signed [15:0] period_ff, period_in;
   logic               halted_ff, halted_in;
   logic               out_valid_ff, out_valid_in;
   cmd_code_type       out_code_ff;
   logic               take;

   assign cmd_ready = !out_valid_ff || !rsp_stall;
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      running_in   = running_ff;
      scale_in     = scale_ff;
      period_in    = period_ff;
      halted_in    = halted_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_PERIOD: period_in = signed'(csr_write_data[15:0]);
            CSR_START_SCALE:  scale_in  = csr_write_data[0];
            default: begin
            end
         endcase
      end
      if (take) begin
         out_valid_in = 1'b1;
         unique case (cmd_data.code)
            CMD_START:   running_in = 1'b1;
            CMD_STOP:    running_in = 1'b0;
            CMD_OFF:     halted_in  = 1'b1;
            CMD_SCALE_C: scale_in   = 1'b0;
            CMD_SCALE_F: scale_in   = 1'b1;
            CMD_PERIOD:  period_in  = cmd_data.value;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b1;
         scale_ff     <= START_SCALE_RESET;
         period_ff    <= START_PERIOD_RESET;
         halted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         scale_ff     <= scale_in;
         period_ff    <= period_in;
         halted_ff    <= halted_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload captured with the state after the line
   always_ff @(posedge clock) begin
      if (take) begin
         out_code_ff          <= cmd_data.code;
         rsp_period_value     <= period_in;
         rsp_running          <= running_in;
         rsp_scale_fahrenheit <= scale_in;
         rsp_shut_down        <= halted_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command_code = out_code_ff;

endmodule : lcr_back
`default_nettype wire

@@ hdl/line_command_recognizer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// line_command_recognizer_core
// Streaming recognizer of newline-terminated text commands.
// ----------------------------------------------------------------------------
// The core takes one text byte per clock unless req_stall is high and never
// buffers a line. START, STOP, OFF, SCALE=C and SCALE=F match only as whole
// lines; a line starting with PERIOD= carries a number read like atoi
// (blanks, optional sign, digits) and saturated to 16 bits signed. Every
// newline yields one result transaction with the command code (0 for empty
// or unknown) and the period, running, scale and shut-down state after that
// line; other bytes yield nothing. After OFF the core swallows every byte,
// without results, until reset. Rate: one byte per cycle sustained while the
// queue has room, set by the combinational keyword compare and decimal
// accumulate in the front end. The front end classifies an accepted newline
// combinationally and writes the queue entry as it is accepted; the back end
// loads its output register from the queue once that register is free or
// being read. A queue of QUEUE_DEPTH entries between them absorbs result-side
// stalls, and req_stall rises only while that queue is full. Configuration
// writes load the period or scale state directly and are meant for idle time.
// ----------------------------------------------------------------------------
module line_command_recognizer_core
   import lcr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // byte input channel
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [7:0]            req_text_byte,
   // result channel
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [2:0]            rsp_command_code,
   output      logic signed [15:0]    rsp_period_value,
   output      logic                  rsp_running,
   output      logic                  rsp_scale_fahrenheit,
   output      logic                  rsp_shut_down,
   // configuration write port
   input  wire logic                  csr_write_enable,
   input  wire logic [0:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   logic          byte_accept;
   logic          push_valid;
   cmd_entry_type push_data;
   logic          queue_full;
   logic          cmd_valid, cmd_ready;
   cmd_entry_type cmd_data;

   // Stall input only when no room is left for a classified line
   assign req_stall   = queue_full;
   assign byte_accept = req_valid && !req_stall;

   lcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(byte_accept),
      .text_byte  (req_text_byte),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   lcr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop_valid (cmd_valid),
      .pop_ready (cmd_ready),
      .pop_data  (cmd_data)
   );

   lcr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (cmd_valid),
      .cmd_ready           (cmd_ready),
      .cmd_data            (cmd_data),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index_type'(csr_index)),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_command_code    (rsp_command_code),
      .rsp_period_value    (rsp_period_value),
      .rsp_running         (rsp_running),
      .rsp_scale_fahrenheit(rsp_scale_fahrenheit),
      .rsp_shut_down       (rsp_shut_down)
   );

endmodule : line_command_recognizer_core
`default_nettype wire

@@ test/lcr_line_checker.sv @@
// ----------------------------------------------------------------------------
// lcr_line_checker
// Watches both channels of the line command recognizer, predicts the result
// of every newline and compares it with what the core sends.
// ----------------------------------------------------------------------------
module lcr_line_checker
   import lcr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [7:0]            req_text_byte,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [2:0]            rsp_command_code,
   input  wire logic signed [15:0]    rsp_period_value,
   input  wire logic                  rsp_running,
   input  wire logic                  rsp_scale_fahrenheit,
   input  wire logic                  rsp_shut_down,
   input  wire logic                  csr_write_enable,
   input  wire logic [0:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output int                         error_count,
   output int                         pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;
   localparam int MAG_CAP     = 32768;
   localparam int POS_CAP     = 32767;
   localparam int LEN_CAP     = 255;

   typedef struct {
      cmd_code_type       code;
      logic signed [15:0] period;
      logic               running;
      logic               scale;
      logic               shut_down;
   } line_result_type;

   line_result_type expected_lines[$];
   int              mismatches;

   // predicted core state
   int                  line_len;
   logic [KW_COUNT-1:0] alive_mask;
   num_phase_type       num_state;
   logic                num_neg;
   int                  num_mag;
   logic                running_flag;
   logic                scale_flag;
   logic signed [15:0]  period_reg;
   logic                halted;

   function automatic string keyword_text(input int k);
      case (k)
         KW_START:  return "START";
         KW_STOP:   return "STOP";
         KW_OFF:    return "OFF";
         KW_SCALEC: return "SCALE=C";
         KW_SCALEF: return "SCALE=F";
         default:   return "PERIOD=";
      endcase
   endfunction

   function automatic cmd_code_type keyword_code(input int k);
      case (k)
         KW_START:  return CMD_START;
         KW_STOP:   return CMD_STOP;
         KW_OFF:    return CMD_OFF;
         KW_SCALEC: return CMD_SCALE_C;
         KW_SCALEF: return CMD_SCALE_F;
         default:   return CMD_PERIOD;
      endcase
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB ||
             c == CHAR_FORMFD || c == CHAR_CR;
   endfunction

   function automatic logic signed [15:0] parsed_period();
      if (num_neg)
         return 16'(32'h10000 - num_mag);
      return 16'((num_mag > POS_CAP) ? POS_CAP : num_mag);
   endfunction

   task automatic clear_line();
      line_len   = 0;
      alive_mask = '1;
      num_state  = NUM_SKIP;
      num_neg    = 1'b0;
      num_mag    = 0;
   endtask

   // atoi-style scan of the bytes after the PERIOD= prefix
   task automatic take_number_byte(input logic [7:0] c);
      if (num_state == NUM_SKIP) begin
         if (is_blank(c))
            return;
         num_state = NUM_DIGITS;
         if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            num_neg = (c == CHAR_MINUS);
            return;
         end
      end
      if (num_state != NUM_DIGITS)
         return;
      if (c < CHAR_ZERO || c > CHAR_NINE) begin
         num_state = NUM_DONE;
         return;
      end
      num_mag = num_mag * 10 + int'(c - CHAR_ZERO);
      if (num_mag > MAG_CAP)
         num_mag = MAG_CAP;
   endtask

   task automatic take_byte(input logic [7:0] c);
      line_result_type r;
      cmd_code_type    code;
      string           w;
      bit              found;
      if (halted)
         return;
      if (c != CHAR_NEWLINE) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (alive_mask[k]) begin
               w = keyword_text(k);
               if (line_len < w.len()) begin
                  if (w[line_len] != c)
                     alive_mask[k] = 1'b0;
               end else if (k != KW_PERIOD) begin
                  alive_mask[k] = 1'b0;
               end
            end
         end
         if (line_len >= keyword_text(KW_PERIOD).len() && alive_mask[KW_PERIOD])
            take_number_byte(c);
         if (line_len < LEN_CAP)
            line_len++;
         return;
      end
      code  = CMD_NONE;
      found = 0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!found && alive_mask[k]) begin
            w = keyword_text(k);
            if ((k == KW_PERIOD) ? (line_len >= w.len()) : (line_len == w.len())) begin
               code  = keyword_code(k);
               found = 1;
            end
         end
      end
      case (code)
         CMD_START:   running_flag = 1'b1;
         CMD_STOP:    running_flag = 1'b0;
         CMD_OFF:     halted       = 1'b1;
         CMD_SCALE_C: scale_flag   = 1'b0;
         CMD_SCALE_F: scale_flag   = 1'b1;
         CMD_PERIOD:  period_reg   = parsed_period();
         default: ;
      endcase
      clear_line();
      r.code      = code;
      r.period    = period_reg;
      r.running   = running_flag;
      r.scale     = scale_flag;
      r.shut_down = halted;
      expected_lines.push_back(r);
   endtask

   task automatic check_result();
      line_result_type want;
      if (expected_lines.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result code %0d period %0d run %0b scale %0b off %0b",
                     $time, rsp_command_code, rsp_period_value, rsp_running,
                     rsp_scale_fahrenheit, rsp_shut_down);
         return;
      end
      want = expected_lines.pop_front();
      if (rsp_command_code !== want.code || rsp_period_value !== want.period ||
          rsp_running !== want.running || rsp_scale_fahrenheit !== want.scale ||
          rsp_shut_down !== want.shut_down) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected code %0d period %0d run %0b scale %0b off %0b",
                     $time, want.code, want.period, want.running, want.scale,
                     want.shut_down);
            $display("%0t:      got code %0d period %0d run %0b scale %0b off %0b",
                     $time, rsp_command_code, rsp_period_value, rsp_running,
                     rsp_scale_fahrenheit, rsp_shut_down);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         running_flag = 1'b1;
         scale_flag   = START_SCALE_RESET;
         period_reg   = START_PERIOD_RESET;
         halted       = 1'b0;
         mismatches   = 0;
         clear_line();
         expected_lines.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_START_PERIOD)
               period_reg = csr_write_data;
            else
               scale_flag = csr_write_data[0];
         end
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            take_byte(req_text_byte);
      end
      error_count     <= mismatches;
      pending_results <= expected_lines.size();
   end

endmodule : lcr_line_checker

@@ test/line_command_recognizer_core_tb.sv @@
// ----------------------------------------------------------------------------
// line_command_recognizer_core_tb
// Byte stream stimulus for the line command recognizer core.
// ----------------------------------------------------------------------------
// Sends directed command lines, then phases of random lines (mostly well
// formed commands with random content, plus mutated keywords and noise),
// changing the start period and scale between phases while the core is idle.
// Both channels idle in random bursts except in the last phase. The run ends
// with an OFF line followed by bytes that must produce nothing. A separate
// checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module line_command_recognizer_core_tb
   import lcr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 1000;   // cycles without any transaction
   localparam int PHASE_BYTES  = 75;     // minimum random bytes per phase
   localparam int SETTLE_TICKS = 4;      // idle ticks after the last result is back
   localparam int TAIL_TICKS   = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_text_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [2:0]            rsp_command_code;
   logic signed [15:0]    rsp_period_value;
   logic                  rsp_running;
   logic                  rsp_scale_fahrenheit;
   logic                  rsp_shut_down;
   logic                  csr_write_enable;
   logic [0:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int error_count;
   int pending_results;

   logic       quiet;        // no idling on either side
   bit         bursty;       // sender may insert gaps in the current line
   int         sent_bytes;
   int         phase_base;
   int         stall_left;
   int         idle_cycles;
   logic [7:0] line_buf[$];

   line_command_recognizer_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_text_byte        (req_text_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_command_code     (rsp_command_code),
      .rsp_period_value     (rsp_period_value),
      .rsp_running          (rsp_running),
      .rsp_scale_fahrenheit (rsp_scale_fahrenheit),
      .rsp_shut_down        (rsp_shut_down),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   lcr_line_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_text_byte        (req_text_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_command_code     (rsp_command_code),
      .rsp_period_value     (rsp_period_value),
      .rsp_running          (rsp_running),
      .rsp_scale_fahrenheit (rsp_scale_fahrenheit),
      .rsp_shut_down        (rsp_shut_down),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .error_count          (error_count),
      .pending_results      (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side back-pressure: rsp_stall rises at random and stays up for a random-length burst.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: any transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("line_command_recognizer_core_tb: errors");
         $finish;
      end
   end

   // One byte transaction; an optional gap goes in front of it. Valid stays
   // high from one accepted byte to the next unless a gap is taken.
   task automatic send_byte(input logic [7:0] b);
      if (!quiet && bursty && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
   endtask

   task automatic send_line();
      bursty = ($urandom_range(0, 3) != 0);
      foreach (line_buf[i])
         send_byte(line_buf[i]);
      send_byte(CHAR_NEWLINE);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      line_buf.delete();
      push_text(s);
      send_line();
   endtask

   function automatic logic [7:0] any_but_newline();
      logic [7:0] b;
      b = $urandom_range(0, 255);
      return (b == CHAR_NEWLINE) ? ~b : b;
   endfunction

   function automatic logic [7:0] any_blank();
      case ($urandom_range(0, 4))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_VTAB;
         3:       return CHAR_FORMFD;
         default: return CHAR_CR;
      endcase
   endfunction

   // Random line: keywords, PERIOD= with random numbers, mutated keywords,
   // noise and empty lines. An exact OFF is never produced here, since it
   // halts the core for the rest of the run.
   task automatic build_random_line();
      int pick;
      int n;
      line_buf.delete();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         case ($urandom_range(0, 3))
            0:       push_text("START");
            1:       push_text("STOP");
            2:       push_text("SCALE=C");
            default: push_text("SCALE=F");
         endcase
      end else if (pick < 70) begin
         push_text("PERIOD=");
         repeat ($urandom_range(0, 3)) line_buf.push_back(any_blank());
         case ($urandom_range(0, 3))
            1:       line_buf.push_back(CHAR_PLUS);
            2:       line_buf.push_back(CHAR_MINUS);
            default: ;
         endcase
         // mostly short numbers, now and then long ones that can saturate
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 5);
         repeat (n) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) line_buf.push_back(any_but_newline());
      end else if (pick < 85) begin
         case ($urandom_range(0, 5))
            0:       push_text("START");
            1:       push_text("STOP");
            2:       push_text("OFF");
            3:       push_text("SCALE=C");
            4:       push_text("SCALE=F");
            default: push_text("PERIOD=");
         endcase
         case ($urandom_range(0, 2))
            0:       repeat ($urandom_range(1, line_buf.size())) void'(line_buf.pop_back());
            1:       line_buf.push_back(any_but_newline());
            default: line_buf[$urandom_range(0, line_buf.size() - 1)] = any_but_newline();
         endcase
      end else if (pick < 95) begin
         repeat ($urandom_range(1, 10)) line_buf.push_back(any_but_newline());
      end
      if (line_buf.size() == 3 && line_buf[0] == "O" && line_buf[1] == "F" &&
          line_buf[2] == "F")
         line_buf.push_back(CHAR_PLUS);
   endtask

   task automatic random_phase(input int nbytes);
      phase_base = sent_bytes;
      while (sent_bytes - phase_base < nbytes) begin
         build_random_line();
         send_line();
      end
   endtask

   // Sender holds off until every expected result is back, then the core
   // is left idle for SETTLE_TICKS to settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Register write; new_settings follows it with an empty line.
   task automatic write_csr(input csr_index_type idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic new_settings(input logic [15:0] period, input logic scale);
      drain();
      write_csr(CSR_START_PERIOD, period);
      write_csr(CSR_START_SCALE, {15'($urandom_range(0, 32767)), scale});
      send_text("");
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_text_byte    <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_START_PERIOD;
      csr_write_data   <= '0;
      quiet            <= 1'b0;
      sent_bytes       = 0;
      bursty           = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed lines with the reset settings ---
      send_text("");
      send_text("START");
      send_text("STOP");
      send_text("SCALE=C");
      send_text("SCALE=F");
      send_text("PERIOD=250");
      // every blank kind ahead of a signed number with trailing junk
      line_buf.delete();
      push_text("PERIOD=");
      line_buf.push_back(CHAR_SPACE);
      line_buf.push_back(CHAR_TAB);
      line_buf.push_back(CHAR_VTAB);
      line_buf.push_back(CHAR_FORMFD);
      line_buf.push_back(CHAR_CR);
      push_text("-42abc");
      send_line();
      send_text("PERIOD=+7");
      send_text("PERIOD=-");          // sign without digits gives zero
      send_text("PERIOD=");
      send_text("PERIOD=99999");      // saturates high
      send_text("PERIOD=-32768");
      send_text("PERIOD=-99999");     // saturates low
      send_text("PERIOD=32767");
      send_text("PERIOD=12 34");      // digits stop at the blank
      line_buf.delete();
      push_text("START");
      line_buf.push_back(CHAR_CR);    // trailing CR makes it unknown
      send_line();
      send_text("STAR");
      send_text("STARTS");
      send_text(" START");
      send_text("PERIOD5");
      send_text("scale=c");
      send_text("OF");
      send_text("OFFX");
      line_buf.delete();
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      line_buf.push_back(8'h7F);
      send_line();
      // line far longer than the position counter can hold
      line_buf.delete();
      push_text("PERIOD=");
      repeat (300) line_buf.push_back(CHAR_SPACE);
      push_text("-17");
      send_line();

      // --- random phases, settings changed while idle ---
      new_settings(16'h8000, 1'b0);
      random_phase(PHASE_BYTES);
      new_settings(16'h7FFF, 1'b1);
      random_phase(PHASE_BYTES);
      new_settings(16'h0000, 1'b0);
      random_phase(PHASE_BYTES);
      drain();
      quiet <= 1'b1;                  // last stretch runs without idling
      new_settings(16'($urandom_range(0, 65535)), 1'b1);
      random_phase(PHASE_BYTES);

      // --- shutdown: OFF reports once, everything after it is swallowed ---
      send_text("OFF");
      send_text("START");
      send_text("");
      send_text("PERIOD=9");

      drain();
      repeat (TAIL_TICKS) @(posedge clock);
      if (error_count == 0 && pending_results == 0)
         $display("line_command_recognizer_core_tb: clean");
      else
         $display("line_command_recognizer_core_tb: errors");
      $finish;
   end

endmodule : line_command_recognizer_core_tb

@@ sim.f @@
hdl/lcr_pkg.sv
hdl/lcr_front.sv
hdl/lcr_queue.sv
hdl/lcr_back.sv
hdl/line_command_recognizer_core.sv
test/lcr_line_checker.sv
test/line_command_recognizer_core_tb.sv
